>>> hdl/float16_round_trip_cast_top_macros.svh
// Assertion macros shared by the float16 round-trip cast design.
`ifndef FLOAT16_ROUND_TRIP_CAST_TOP_MACROS_SVH
`define FLOAT16_ROUND_TRIP_CAST_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define F16RT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define F16RT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/f16rt_pkg.sv
// Types and constants for the float16 round-trip cast design.
package f16rt_pkg;

    // Largest finite half magnitude (65504) and single infinity, as single bit patterns.
    localparam logic [31:0] HALF_MAX_MAG = 32'h477F_E000;
    localparam logic [31:0] F32_INF_MAG  = 32'h7F80_0000;

    // Difference between the single and half exponent biases.
    localparam logic signed [9:0] EXP_BIAS_DIFF = 10'sd112;
    // Rebased exponents that bound the flush, subnormal and infinity ranges.
    localparam logic signed [9:0] HALF_FLUSH_EXP = -10'sd10;
    localparam logic signed [9:0] HALF_ZERO_EXP  = 10'sd0;
    localparam logic signed [9:0] HALF_SUB_SHIFT = 10'sd14;
    localparam logic signed [9:0] HALF_EXP_INF   = 10'sd31;

    // Half an ulp of the half mantissa, placed in the single mantissa.
    localparam logic [23:0] HALF_ROUND = 24'h00_1000;
    // Exponent and mantissa field of a half infinity.
    localparam logic [14:0] HALF_INF = 15'h7C00;

    localparam logic [4:0] HALF_EXP_MAX   = 5'h1F;
    localparam logic [7:0] F32_EXP_MAX    = 8'hFF;
    localparam logic [7:0] F32_REBIAS     = 8'd112;
    // Single exponent of a normalized half subnormal is this plus the leading-one index.
    localparam logic [7:0] SUB_EXP_BASE   = 8'd103;

    typedef struct packed {
        logic [15:0] half_bits;
        logic [31:0] widened_bits;
        logic        overflow;
    } f16rt_result_t;

endpackage

>>> hdl/float16_round_trip_cast_top.sv
// Top level of the float16 round-trip cast: input register, converter, result register.
// A result is registered in the result register after its item passes the input register and converter.
// Throughput is one item per cycle while the consumer keeps m_ready high.
// Back-pressure propagates through both registers, so items are held and never dropped.
// Synchronous active-low reset clears both valid flags; payload registers are not reset.
`include "float16_round_trip_cast_top_macros.svh"

module float16_round_trip_cast_top (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_value_bits,
    input  logic        s_last_in,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_half_bits,
    output logic [31:0] m_widened_bits,
    output logic        m_overflow,
    output logic        m_last_out
);

    // The input register holds one item for the converter.
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [31:0] in_value_reg;
    logic        in_last_reg;

    // The result register holds one finished item until the consumer takes it.
    logic                     out_valid_reg;
    logic                     out_valid_next;
    f16rt_pkg::f16rt_result_t out_result_reg;
    logic                     out_last_reg;

    f16rt_pkg::f16rt_result_t conv_result;

    logic out_ready;
    logic in_load;
    logic out_load;

    // The result register can take a new item when empty or being drained this cycle.
    assign out_ready = !out_valid_reg || m_ready;
    // The input register can take a new item when empty or moving forward this cycle.
    assign s_ready   = !in_valid_reg || out_ready;
    assign in_load   = s_valid && s_ready;
    assign out_load  = in_valid_reg && out_ready;

    f16rt_convert u_convert (
        .value_bits (in_value_reg),
        .result     (conv_result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_load) begin
            in_valid_next = 1'b1;
        end else if (out_load) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers load only on a transfer into their stage.
    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_value_reg <= s_value_bits;
            in_last_reg  <= s_last_in;
        end
        if (out_load) begin
            out_result_reg <= conv_result;
            out_last_reg   <= in_last_reg;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_half_bits    = out_result_reg.half_bits;
    assign m_widened_bits = out_result_reg.widened_bits;
    assign m_overflow     = out_result_reg.overflow;
    assign m_last_out     = out_last_reg;

    // An overflowing item carries zero bit patterns in both result fields.
    `F16RT_ASSERT_NOW(a_ovf_zero, aclk, aresetn, m_valid && m_overflow,
        m_half_bits == 16'd0 && m_widened_bits == 32'd0, "overflow item has nonzero bits")

    // With both registers full and the consumer stalled, no new item may enter.
    `F16RT_ASSERT_NOW(a_full_stall, aclk, aresetn, in_valid_reg && out_valid_reg && !m_ready,
        !s_ready, "input accepted while pipeline is full and stalled")

    // An accepted item always occupies the input register on the next cycle.
    `F16RT_ASSERT_NEXT(a_in_load, aclk, aresetn, s_valid && s_ready,
        in_valid_reg, "accepted item lost from input register")

    // A half infinity always widens to a single with an all-ones exponent.
    `F16RT_ASSERT_NOW(a_inf_widen, aclk, aresetn,
        m_valid && m_half_bits[14:10] == f16rt_pkg::HALF_EXP_MAX,
        m_widened_bits[30:23] == f16rt_pkg::F32_EXP_MAX, "half infinity widened wrongly")

endmodule

>>> hdl/f16rt_convert.sv
// Combinational narrowing of one single to half and widening of it back to single.
module f16rt_convert (
    input  logic [31:0]               value_bits,
    output f16rt_pkg::f16rt_result_t  result
);

    logic              sign;
    logic [31:0]       mag;
    logic              ovf;
    logic signed [9:0] exp_half;
    logic [4:0]        sub_shift;
    logic [24:0]       sub_sum;
    logic [24:0]       sub_q;
    logic [23:0]       norm_sum;
    logic signed [9:0] exp_round;
    logic [15:0]       half;
    logic [4:0]        he;
    logic [9:0]        hm;
    logic [3:0]        lead;
    logic [10:0]       norm_m;
    logic [31:0]       widened;

    assign sign = value_bits[31];
    assign mag  = {1'b0, value_bits[30:0]};
    assign ovf  = (mag > f16rt_pkg::HALF_MAX_MAG) && (mag <= f16rt_pkg::F32_INF_MAG);

    assign exp_half = $signed({2'b00, value_bits[30:23]}) - f16rt_pkg::EXP_BIAS_DIFF;

    // Subnormal path: the implicit one is kept and the sum is shifted right by 14 to 24.
    assign sub_shift = 5'(f16rt_pkg::HALF_SUB_SHIFT - exp_half);
    assign sub_sum   = {2'b01, value_bits[22:0]} + (25'd1 << (sub_shift - 5'd1));
    assign sub_q     = sub_sum >> sub_shift;

    // Normal path: a carry out of the mantissa leaves the kept bits zero and bumps the exponent.
    assign norm_sum  = {1'b0, value_bits[22:0]} + f16rt_pkg::HALF_ROUND;
    assign exp_round = exp_half + $signed({9'd0, norm_sum[23]});

    always_comb begin
        if (ovf) begin
            half = '0;
        end else if (exp_half < f16rt_pkg::HALF_FLUSH_EXP) begin
            half = {sign, 15'd0};
        end else if (exp_half <= f16rt_pkg::HALF_ZERO_EXP) begin
            half = {sign, 4'd0, sub_q[10:0]};
        end else if (exp_round >= f16rt_pkg::HALF_EXP_INF) begin
            half = {sign, f16rt_pkg::HALF_INF};
        end else begin
            half = {sign, exp_round[4:0], norm_sum[22:13]};
        end
    end

    assign he = half[14:10];
    assign hm = half[9:0];

    // The highest set bit of a subnormal mantissa sets the normalizing shift.
    always_comb begin
        lead = '0;
        for (int i = 0; i < 10; i++) begin
            if (hm[i]) begin
                lead = 4'(i);
            end
        end
    end

    assign norm_m = {1'b0, hm} << (4'd10 - lead);

    always_comb begin
        if (he == 5'd0) begin
            if (hm == 10'd0) begin
                widened = {half[15], 31'd0};
            end else begin
                widened = {half[15], 8'({4'd0, lead}) + f16rt_pkg::SUB_EXP_BASE,
                           norm_m[9:0], 13'd0};
            end
        end else if (he == f16rt_pkg::HALF_EXP_MAX) begin
            widened = {half[15], f16rt_pkg::F32_EXP_MAX, hm, 13'd0};
        end else begin
            widened = {half[15], 8'({3'd0, he}) + f16rt_pkg::F32_REBIAS, hm, 13'd0};
        end
    end

    assign result.half_bits    = half;
    assign result.widened_bits = widened;
    assign result.overflow     = ovf;

endmodule
